[sv/ctsp_pkg.sv]
// Caption timestamp parser: shared constants and types.
// Used by ctsp_parser and caption_timestamp_parser_core; no dependencies.
`default_nettype none

package ctsp_pkg;

    localparam int TIME_W = 46;
    localparam int REST_W = 22;
    localparam int MSPH_W = 22;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [6:0] MAX_MIN_SEC = 7'd59;
    localparam logic [2:0] RUN_MAX     = 3'd7;
    localparam logic [2:0] RUN_PAIR    = 3'd2;
    localparam logic [2:0] RUN_TRIPLE  = 3'd3;

    localparam logic [MSPH_W-1:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0]       MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]        MS_PER_SEC  = 10'd1000;

    // Per-character outcome of the parser, minus the parameter-sized fields.
    typedef struct packed {
        logic       emit;
        logic       ok;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [9:0] fraction;
    } ctsp_done_t;

endpackage

`default_nettype wire

[sv/ctsp_parser.sv]
// Timestamp grammar state machine, one character per accepted request.
// Depends on ctsp_pkg.
`default_nettype none

module ctsp_parser #(
    parameter int HOUR_WIDTH    = 24,
    parameter int MAX_TOKEN_LEN = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_fire,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               start_req,
    input  wire logic                               end_of_text,
    output ctsp_pkg::ctsp_done_t                    done,
    output logic [HOUR_WIDTH-1:0]                   hours,
    output logic [$clog2(MAX_TOKEN_LEN+1)-1:0]      consumed
);
    import ctsp_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ACC_W = HOUR_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_IDLE, PH_D1, PH_C1, PH_D2, PH_C2, PH_D3, PH_DOT, PH_D4
    } phase_t;

    phase_t                 phase_reg,  phase_next;
    logic                   hours_reg,  hours_next;
    logic [2:0]             run_reg,    run_next;
    logic [HOUR_WIDTH-1:0]  first_reg,  first_next;
    logic [6:0]             second_reg, second_next;
    logic [6:0]             third_reg,  third_next;
    logic [9:0]             frac_reg,   frac_next;
    logic [CNT_W-1:0]       count_reg,  count_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [2:0]             run_inc;
    logic [CNT_W-1:0]       count_inc;
    logic [ACC_W-1:0]       first_acc;
    logic [HOUR_WIDTH-1:0]  first_sat;
    logic                   emit;
    logic                   finish_now;
    logic [6:0]             min_sel;
    logic [6:0]             sec_sel;

    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit     = is_digit ? 4'(char_code - CHAR_ZERO) : 4'd0;
    assign run_inc   = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 3'd1;
    assign count_inc = (count_reg < CNT_W'(MAX_TOKEN_LEN)) ? count_reg + CNT_W'(1) : count_reg;
    assign first_acc = (ACC_W'(first_reg) << 3) + (ACC_W'(first_reg) << 1) + ACC_W'(digit);
    assign first_sat = (|first_acc[ACC_W-1:HOUR_WIDTH]) ? {HOUR_WIDTH{1'b1}}
                                                         : first_acc[HOUR_WIDTH-1:0];

    always_comb begin
        phase_next  = phase_reg;
        hours_next  = hours_reg;
        run_next    = run_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        frac_next   = frac_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        finish_now  = 1'b0;
        if (in_fire) begin
            if (start_req) begin
                hours_next  = 1'b0;
                run_next    = 3'd0;
                first_next  = '0;
                second_next = '0;
                third_next  = '0;
                frac_next   = '0;
                count_next  = '0;
                if (!is_digit) begin
                    emit = 1'b1;
                end else begin
                    phase_next = PH_D1;
                    run_next   = 3'd1;
                    first_next = HOUR_WIDTH'(digit);
                    count_next = CNT_W'(1);
                end
            end else begin
                case (phase_reg)
                    PH_D1: begin
                        count_next = count_inc;
                        if (is_digit) begin
                            run_next   = run_inc;
                            first_next = first_sat;
                        end else begin
                            hours_next = (run_reg != RUN_PAIR) ||
                                         (first_reg > HOUR_WIDTH'(MAX_MIN_SEC));
                            if (char_code != CHAR_COLON) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_C1;
                            end
                        end
                    end
                    PH_C1, PH_C2, PH_DOT: begin
                        if (!is_digit) begin
                            emit = 1'b1;
                        end else begin
                            run_next   = 3'd1;
                            count_next = count_inc;
                            if (phase_reg == PH_C1) begin
                                second_next = 7'(digit);
                                phase_next  = PH_D2;
                            end else if (phase_reg == PH_C2) begin
                                third_next = 7'(digit);
                                phase_next = PH_D3;
                            end else begin
                                frac_next  = 10'(digit);
                                phase_next = PH_D4;
                            end
                        end
                    end
                    PH_D2, PH_D3: begin
                        if (is_digit) begin
                            run_next   = run_inc;
                            count_next = count_inc;
                            if (run_inc <= RUN_PAIR) begin
                                if (phase_reg == PH_D2) begin
                                    second_next = 7'(second_reg * 7'd10 + 7'(digit));
                                end else begin
                                    third_next = 7'(third_reg * 7'd10 + 7'(digit));
                                end
                            end
                        end else if (run_reg != RUN_PAIR) begin
                            emit = 1'b1;
                        end else begin
                            count_next = count_inc;
                            if (phase_reg == PH_D2 && (hours_reg || char_code == CHAR_COLON)) begin
                                hours_next = 1'b1;
                                if (char_code != CHAR_COLON) begin
                                    emit = 1'b1;
                                end else begin
                                    phase_next = PH_C2;
                                end
                            end else if (char_code != CHAR_DOT) begin
                                emit = 1'b1;
                            end else begin
                                phase_next = PH_DOT;
                            end
                        end
                    end
                    PH_D4: begin
                        if (is_digit) begin
                            run_next   = run_inc;
                            count_next = count_inc;
                            if (run_inc <= RUN_TRIPLE) begin
                                frac_next = 10'(frac_reg * 10'd10 + 10'(digit));
                            end
                        end else begin
                            finish_now = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (end_of_text && !emit && !finish_now && phase_next != PH_IDLE) begin
                if (phase_next == PH_D4) begin
                    finish_now = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
        end
        if (finish_now) begin
            emit = 1'b1;
        end
        if (emit) begin
            phase_next = PH_IDLE;
        end
    end

    // minutes come from the first group unless hours are present
    assign min_sel = hours_next ? second_next : first_next[6:0];
    assign sec_sel = hours_next ? third_next : second_next;

    assign done.emit     = emit;
    assign done.ok       = finish_now && (run_next == RUN_TRIPLE) &&
                           (min_sel <= MAX_MIN_SEC) && (sec_sel <= MAX_MIN_SEC);
    assign done.minutes  = min_sel;
    assign done.seconds  = sec_sel;
    assign done.fraction = frac_next;
    assign hours         = hours_next ? first_next : '0;
    assign consumed      = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            hours_reg  <= 1'b0;
            run_reg    <= 3'd0;
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            frac_reg   <= '0;
            count_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            hours_reg  <= hours_next;
            run_reg    <= run_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            frac_reg   <= frac_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/caption_timestamp_parser_core.sv]
// Caption timestamp parser top level: stream ports, parser, millisecond pipeline.
// Depends on ctsp_pkg and ctsp_parser.
//
// Parses [hours:]mm:ss.ttt from a byte stream, one character per cycle while
// s_tready is high, with no gaps needed. An attempt opens on a request with
// s_tuser set and yields at most one result: valid flag, time in milliseconds
// (zero when malformed) and the character count. The grammar state updates
// once per accepted character; the result then passes a capture stage, an hours
// multiply stage and an output register, which drives m_tvalid. Each stage has
// its own valid bit, so input keeps flowing while a result waits on m_tready
// until all three stages are full.
`default_nettype none

module caption_timestamp_parser_core #(
    parameter int HOUR_WIDTH    = 24,
    parameter int MAX_TOKEN_LEN = 64
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // char_code
    input  wire logic                    s_tuser,   // start_req
    input  wire logic                    s_tlast,   // end_of_text
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // valid_res, time_ms[45:0], consumed, zero pad
    output logic [((47 + $clog2(MAX_TOKEN_LEN+1) + 7) / 8) * 8 - 1:0] m_tdata
);
    import ctsp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_TOKEN_LEN + 1);
    localparam int OUT_W   = 1 + TIME_W + CNT_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int PROD_W  = (HOUR_WIDTH + MSPH_W > TIME_W) ? HOUR_WIDTH + MSPH_W : TIME_W;

    logic                    in_fire;
    ctsp_done_t              done;
    logic [HOUR_WIDTH-1:0]   hours;
    logic [CNT_W-1:0]        consumed;

    logic                    p2_ready;
    logic                    out_ready;

    logic                    p1_valid_reg;
    ctsp_done_t              p1_done_reg;
    logic [HOUR_WIDTH-1:0]   p1_hours_reg;
    logic [CNT_W-1:0]        p1_count_reg;

    logic                    p2_valid_reg;
    logic                    p2_ok_reg;
    logic [TIME_W-1:0]       p2_hours_ms_reg;
    logic [REST_W-1:0]       p2_rest_reg;
    logic [CNT_W-1:0]        p2_count_reg;

    logic                    out_valid_reg;
    logic                    out_ok_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic [CNT_W-1:0]        out_count_reg;

    logic [PROD_W-1:0]       hours_prod;
    logic [REST_W-1:0]       rest_ms;

    assign out_ready = !out_valid_reg || m_tready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign s_tready  = !p1_valid_reg || p2_ready;
    assign in_fire   = s_tvalid && s_tready;

    ctsp_parser #(
        .HOUR_WIDTH    (HOUR_WIDTH),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .char_code   (s_tdata),
        .start_req   (s_tuser),
        .end_of_text (s_tlast),
        .done        (done),
        .hours       (hours),
        .consumed    (consumed)
    );

    assign hours_prod = PROD_W'(p1_hours_reg) * PROD_W'(MS_PER_HOUR);
    assign rest_ms    = REST_W'(p1_done_reg.minutes) * REST_W'(MS_PER_MIN)
                      + REST_W'(p1_done_reg.seconds) * REST_W'(MS_PER_SEC)
                      + REST_W'(p1_done_reg.fraction);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                p1_valid_reg <= in_fire && done.emit;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            p1_done_reg  <= done;
            p1_hours_reg <= hours;
            p1_count_reg <= consumed;
        end
        if (p2_ready) begin
            p2_ok_reg       <= p1_done_reg.ok;
            p2_hours_ms_reg <= hours_prod[TIME_W-1:0];
            p2_rest_reg     <= rest_ms;
            p2_count_reg    <= p1_count_reg;
        end
        if (out_ready) begin
            out_ok_reg    <= p2_ok_reg;
            out_time_reg  <= p2_ok_reg ? p2_hours_ms_reg + TIME_W'(p2_rest_reg) : '0;
            out_count_reg <= p2_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_count_reg, out_time_reg, out_ok_reg});

    a_bad_time_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ok_reg) |-> (out_time_reg == '0))
        else $error("malformed result carries nonzero time");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_count_reg <= CNT_W'(MAX_TOKEN_LEN)))
        else $error("consumed count above limit");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !p1_valid_reg |-> s_tready)
        else $error("input stalled with empty capture stage");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && !s_tvalid) |=> !p1_valid_reg)
        else $error("result captured without a request");

endmodule

`default_nettype wire
